/* rtl/etq_pkg.sv */
package etq_pkg;

    localparam int ANGLE_BITS_DEF    = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int CORDIC_STAGES_DEF = 16;

    // rotator words: x, y in Q2.30 with headroom, residual angle in 2^-33 turn
    localparam int ROT_W  = 34;
    // cosine and sine handed to the multipliers, signed Q1.30
    localparam int TRIG_W = 32;
    // full products, Q60
    localparam int PROD_W = 64;
    // the half angle is scaled so that 2^31 stands for pi/2
    localparam int HALF_ANGLE_BITS = 32;

    // axis order inside the rotator and trig sets
    localparam int AX_PITCH = 0;
    localparam int AX_ROLL  = 1;
    localparam int AX_YAW   = 2;
    localparam int N_AXES   = 3;

    typedef logic signed [ROT_W-1:0]  t_rot_word;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef struct packed {
        t_rot_word x;
        t_rot_word y;
        t_rot_word z;
    } t_rot;

    typedef t_rot [N_AXES-1:0] t_rot_set;

    typedef struct packed {
        t_trig c;
        t_trig s;
    } t_trig_pair;

    typedef t_trig_pair [N_AXES-1:0] t_trig_set;

    // inverse CORDIC gain, Q30
    localparam t_rot_word GAIN_Q30 = 34'sd652032874;

    // arctangent of 2^-idx, in units of 2^-33 of a turn (table held at half scale and doubled)
    function automatic t_rot_word atan_step(input logic [4:0] idx);
        logic [30:0] a;
        case (idx)
            5'd0:  a = 31'd536870912;
            5'd1:  a = 31'd316933406;
            5'd2:  a = 31'd167458907;
            5'd3:  a = 31'd85004756;
            5'd4:  a = 31'd42667331;
            5'd5:  a = 31'd21354465;
            5'd6:  a = 31'd10679838;
            5'd7:  a = 31'd5340245;
            5'd8:  a = 31'd2670163;
            5'd9:  a = 31'd1335087;
            5'd10: a = 31'd667544;
            5'd11: a = 31'd333772;
            5'd12: a = 31'd166886;
            5'd13: a = 31'd83443;
            5'd14: a = 31'd41722;
            5'd15: a = 31'd20861;
            5'd16: a = 31'd10430;
            5'd17: a = 31'd5215;
            5'd18: a = 31'd2608;
            5'd19: a = 31'd1304;
            5'd20: a = 31'd652;
            5'd21: a = 31'd326;
            5'd22: a = 31'd163;
            5'd23: a = 31'd81;
            5'd24: a = 31'd41;
            5'd25: a = 31'd20;
            5'd26: a = 31'd10;
            5'd27: a = 31'd5;
            5'd28: a = 31'd3;
            5'd29: a = 31'd1;
            5'd30: a = 31'd1;
            default: a = 31'd0;
        endcase
        return t_rot_word'({a, 1'b0});
    endfunction

endpackage

/* rtl/etq_cordic_cell.sv */
module etq_cordic_cell
    import etq_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_rot_set i_data,
    output logic     o_valid,
    input  logic     i_ready,
    output t_rot_set o_data
);

    localparam t_rot_word STEP = atan_step(5'(STAGE));

    logic     r_valid;
    t_rot_set r_data;
    t_rot_set n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    for (genvar k = 0; k < N_AXES; k++) begin : g_axis
        t_rot_word x, y, z, dx, dy;
        logic      pos;

        assign x   = i_data[k].x;
        assign y   = i_data[k].y;
        assign z   = i_data[k].z;
        assign dx  = y >>> STAGE;
        assign dy  = x >>> STAGE;
        assign pos = !z[ROT_W-1];

        // rotate towards zero residual angle
        assign n_data[k].x = pos ? x - dx   : x + dx;
        assign n_data[k].y = pos ? y + dy   : y - dy;
        assign n_data[k].z = pos ? z - STEP : z + STEP;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

/* rtl/etq_combine.sv */
module etq_combine
    import etq_pkg::*;
#(
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  t_trig_set                        i_trig,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [OUT_FRAC_BITS+1:0]  o_scalar,
    output logic signed [OUT_FRAC_BITS+1:0]  o_vec_x,
    output logic signed [OUT_FRAC_BITS+1:0]  o_vec_y,
    output logic signed [OUT_FRAC_BITS+1:0]  o_vec_z
);

    localparam int    OUT_W    = OUT_FRAC_BITS + 2;
    localparam int    SH       = 60 - OUT_FRAC_BITS;
    localparam t_prod HALF_Q30 = t_prod'(64'sd1 <<< 29);
    localparam t_prod RND      = t_prod'(64'sd1 <<< (SH - 1));
    localparam t_prod LIM      = t_prod'(64'sd1 <<< OUT_FRAC_BITS);

    // pair products: cy*cr, sy*sr, cy*sr, sy*cr
    localparam int PR_A = 0;
    localparam int PR_B = 1;
    localparam int PR_C = 2;
    localparam int PR_D = 3;

    logic r_va, r_vb, r_vc;
    logic rdy_a, rdy_b, rdy_c;

    assign rdy_c   = !r_vc || i_ready;
    assign rdy_b   = !r_vb || rdy_c;
    assign rdy_a   = !r_va || rdy_b;
    assign o_ready = rdy_a;
    assign o_valid = r_vc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else begin
            if (rdy_a) r_va <= i_valid;
            if (rdy_b) r_vb <= r_va;
            if (rdy_c) r_vc <= r_vb;
        end
    end

    // stage A: pair products rounded back to Q30
    t_prod m_pair [4];
    t_trig r_pair [4];
    t_trig r_cp, r_sp;

    assign m_pair[PR_A] = t_prod'(i_trig[AX_YAW].c) * t_prod'(i_trig[AX_ROLL].c);
    assign m_pair[PR_B] = t_prod'(i_trig[AX_YAW].s) * t_prod'(i_trig[AX_ROLL].s);
    assign m_pair[PR_C] = t_prod'(i_trig[AX_YAW].c) * t_prod'(i_trig[AX_ROLL].s);
    assign m_pair[PR_D] = t_prod'(i_trig[AX_YAW].s) * t_prod'(i_trig[AX_ROLL].c);

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            for (int k = 0; k < 4; k++) begin
                r_pair[k] <= t_trig'((m_pair[k] + HALF_Q30) >>> 30);
            end
            r_cp <= i_trig[AX_PITCH].c;
            r_sp <= i_trig[AX_PITCH].s;
        end
    end

    // stage B: Q60 products with the half pitch terms
    t_prod r_a_cp, r_a_sp, r_b_cp, r_b_sp, r_c_cp, r_c_sp, r_d_cp, r_d_sp;

    always_ff @(posedge i_clk) begin
        if (rdy_b && r_va) begin
            r_a_cp <= t_prod'(r_pair[PR_A]) * t_prod'(r_cp);
            r_a_sp <= t_prod'(r_pair[PR_A]) * t_prod'(r_sp);
            r_b_cp <= t_prod'(r_pair[PR_B]) * t_prod'(r_cp);
            r_b_sp <= t_prod'(r_pair[PR_B]) * t_prod'(r_sp);
            r_c_cp <= t_prod'(r_pair[PR_C]) * t_prod'(r_cp);
            r_c_sp <= t_prod'(r_pair[PR_C]) * t_prod'(r_sp);
            r_d_cp <= t_prod'(r_pair[PR_D]) * t_prod'(r_cp);
            r_d_sp <= t_prod'(r_pair[PR_D]) * t_prod'(r_sp);
        end
    end

    // stage C: sum, round to output precision, clamp to plus or minus one
    t_prod sum [4];
    t_prod rnd [4];
    logic signed [OUT_W-1:0] sat [4];
    logic signed [OUT_W-1:0] r_out [4];

    assign sum[0] = r_a_cp + r_b_sp;
    assign sum[1] = r_c_cp - r_d_sp;
    assign sum[2] = r_a_sp + r_b_cp;
    assign sum[3] = r_d_cp - r_c_sp;

    for (genvar k = 0; k < 4; k++) begin : g_out
        assign rnd[k] = (sum[k] + RND) >>> SH;
        assign sat[k] = (rnd[k] > LIM)  ? OUT_W'(LIM)  :
                        (rnd[k] < -LIM) ? OUT_W'(-LIM) : OUT_W'(rnd[k]);
    end

    always_ff @(posedge i_clk) begin
        if (rdy_c && r_vb) begin
            for (int k = 0; k < 4; k++) begin
                r_out[k] <= sat[k];
            end
        end
    end

    assign o_scalar = r_out[0];
    assign o_vec_x  = r_out[1];
    assign o_vec_y  = r_out[2];
    assign o_vec_z  = r_out[3];

endmodule

/* rtl/euler_to_quaternion.sv */
// Euler angles to quaternion. Each request carries pitch, roll and yaw as signed
// binary angles (the full code range spans -pi to +pi); each result carries the
// quaternion scalar part and x, y, z as signed Q1.OUT_FRAC_BITS, clamped to
// plus or minus one. The block keeps no state between requests and takes one
// request every cycle until back-pressure from the output fills its stages;
// the pipeline is the row of CORDIC cells (one rotation step each, all three
// angles side by side) followed by three multiply and rounding stages. Every
// stage holds its request when the next one is full, so bubbles close up and
// requests keep being taken while a result waits at the output.
module euler_to_quaternion
    import etq_pkg::*;
#(
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF,
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // pitch_angle, roll_angle, yaw_angle
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]            s_tdata,
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // scalar_part, vec_x, vec_y, vec_z
    output logic [((4*(OUT_FRAC_BITS+2)+7)/8)*8-1:0]     m_tdata
);

    localparam int IN_SHIFT  = HALF_ANGLE_BITS - ANGLE_BITS;
    localparam int OUT_W     = OUT_FRAC_BITS + 2;
    localparam int OUT_TDATA = ((4*OUT_W+7)/8)*8;

    t_rot_set chain_data  [CORDIC_STAGES+1];
    logic     chain_valid [CORDIC_STAGES+1];
    logic     chain_ready [CORDIC_STAGES+1];

    // half angle: scale the input so that 2^31 is pi/2, start at the gain constant
    for (genvar k = 0; k < N_AXES; k++) begin : g_in
        logic signed [ANGLE_BITS-1:0] ang;

        assign ang = s_tdata[k*ANGLE_BITS +: ANGLE_BITS];
        assign chain_data[0][k].x = GAIN_Q30;
        assign chain_data[0][k].y = '0;
        assign chain_data[0][k].z = t_rot_word'(ang) <<< IN_SHIFT;
    end

    assign chain_valid[0] = s_tvalid;
    assign s_tready       = chain_ready[0];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        etq_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[i]),
            .o_ready (chain_ready[i]),
            .i_data  (chain_data[i]),
            .o_valid (chain_valid[i+1]),
            .i_ready (chain_ready[i+1]),
            .o_data  (chain_data[i+1])
        );
    end

    t_trig_set trig;

    for (genvar k = 0; k < N_AXES; k++) begin : g_trig
        assign trig[k].c = chain_data[CORDIC_STAGES][k].x[TRIG_W-1:0];
        assign trig[k].s = chain_data[CORDIC_STAGES][k].y[TRIG_W-1:0];
    end

    logic signed [OUT_W-1:0] scalar_part, vec_x, vec_y, vec_z;

    etq_combine #(
        .OUT_FRAC_BITS (OUT_FRAC_BITS)
    ) u_combine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (chain_valid[CORDIC_STAGES]),
        .o_ready  (chain_ready[CORDIC_STAGES]),
        .i_trig   (trig),
        .o_valid  (m_tvalid),
        .i_ready  (m_tready),
        .o_scalar (scalar_part),
        .o_vec_x  (vec_x),
        .o_vec_y  (vec_y),
        .o_vec_z  (vec_z)
    );

    assign m_tdata = OUT_TDATA'({vec_z, vec_y, vec_x, scalar_part});

endmodule
